// ----- rtl/core/nnis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_pkg: shared types and constants of the nearest neighbor scaler
// Word formats, command and status groups, size clamping helper.
// ----------------------------------------------------------------------------
package nnis_pkg;

    localparam int CFG_W  = 9;                 // size register width
    localparam int POS_W  = CFG_W;             // output position counter width
    localparam int CH_W   = 8;                 // one color channel
    localparam int PIX_W  = 3 * CH_W;          // stored pixel: blue low, then green, red
    localparam int ROW_W  = 8;                 // reported row / column width
    localparam int MAXV_W = 13;                // holds the largest size limit
    localparam int NUM_W  = 2 * CFG_W + 3;     // mapping numerator width
    localparam int DVS_W  = CFG_W + 2;         // mapping divisor width
    localparam int STEP_W = $clog2(CFG_W);     // divider step counter width

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);
    localparam logic [CH_W-1:0]  CH_WHITE  = '1;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } op_t;

    typedef struct packed {
        op_t             operation;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_red;
    } req_word_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_blue;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_red;
        logic [ROW_W-1:0] out_row;
        logic [ROW_W-1:0] out_col;
        logic             filled_white;
        logic             frame_last;
    } rsp_word_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // write pixel, advance load index
        logic setup;      // build numerator, divisor, limit
        logic check;      // range check, arm divider
        logic step;       // one quotient bit
        logic addr;       // register store address
        logic out_load;   // fill output register, advance position
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } sts_t;

    // Zero reads as one, anything above the limit saturates to it
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0]  v,
                                                    input logic [MAXV_W-1:0] maxv);
        logic [MAXV_W-1:0] v_ext;
        v_ext = MAXV_W'(v);
        if (v == '0)
            return CFG_W'(1);
        else if (v_ext > maxv)
            return maxv[CFG_W-1:0];
        else
            return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/nnis_map.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_map: coordinate mapper for one axis
// Maps an output position to a source position with a restoring divider,
// one quotient bit per step, and flags positions that fall outside.
// ----------------------------------------------------------------------------
module nnis_map
(
    input  logic                       clk,
    input  nnis_pkg::cmd_t             cmd,
    input  logic [nnis_pkg::POS_W-1:0] pos,
    input  logic [nnis_pkg::CFG_W-1:0] src,
    input  logic [nnis_pkg::CFG_W-1:0] dst,
    output logic [nnis_pkg::CFG_W-1:0] quot,
    output logic                       outside
);
    import nnis_pkg::*;

    logic [2*CFG_W-1:0] pos_prod;
    logic [NUM_W-1:0]   num_next;
    logic [DVS_W-1:0]   dvs_next;
    logic [NUM_W-1:0]   lim_next;
    logic [NUM_W-1:0]   trial;

    logic [NUM_W-1:0]   rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [NUM_W-1:0]   lim_reg;
    logic [NUM_W-1:0]   shd_reg;
    logic [CFG_W-1:0]   quot_reg;
    logic               outside_reg;

    // numerator 4*pos*src + 2*dst - 1, divisor 2*(2*dst - 1)
    assign pos_prod = (2*CFG_W)'(pos) * (2*CFG_W)'(src);
    assign num_next = NUM_W'({pos_prod, 2'b00}) + NUM_W'({dst, 1'b0}) - NUM_W'(1);
    assign dvs_next = DVS_W'({dst, 2'b00}) - DVS_W'(2);
    // quotient stays below src exactly when numerator is below divisor*src
    assign lim_next = NUM_W'(dvs_next) * NUM_W'(src);
    assign trial    = rem_reg - shd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            rem_reg <= num_next;
            dvs_reg <= dvs_next;
            lim_reg <= lim_next;
        end
        else if (cmd.check)
        begin
            outside_reg <= (rem_reg >= lim_reg);
            shd_reg     <= NUM_W'(dvs_reg) << (CFG_W - 1);
            quot_reg    <= '0;
        end
        else if (cmd.step)
        begin
            if (rem_reg >= shd_reg)
            begin
                rem_reg  <= trial;
                quot_reg <= {quot_reg[CFG_W-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[CFG_W-2:0], 1'b0};
            end
            shd_reg <= shd_reg >> 1;
        end
    end

    assign quot    = quot_reg;
    assign outside = outside_reg;

endmodule
`default_nettype wire

// ----- rtl/core/nnis_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_dp: scaler datapath
// Size registers, pixel store, load and output position counters, two axis
// mappers, store address, and the output word register.
// ----------------------------------------------------------------------------
module nnis_dp
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  nnis_pkg::cfg_index_t       cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0] cfg_data,
    input  nnis_pkg::req_word_t        req_word,
    input  logic                       rsp_ready,
    output logic                       rsp_valid,
    output nnis_pkg::rsp_word_t        rsp_word,
    input  nnis_pkg::cmd_t             cmd,
    output nnis_pkg::sts_t             sts
);
    import nnis_pkg::*;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int CMP_W       = ((ADDR_W > PROD_W) ? ADDR_W : PROD_W) + 1;

    localparam logic [MAXV_W-1:0] SRC_W_MAX = MAXV_W'(MAX_SRC_WIDTH);
    localparam logic [MAXV_W-1:0] SRC_H_MAX = MAXV_W'(MAX_SRC_HEIGHT);
    localparam logic [MAXV_W-1:0] DST_MAX   = MAXV_W'(MAX_DST_DIM);
    localparam logic [CFG_W-1:0]  SRC_W_RST = clamp_size(CFG_RESET, SRC_W_MAX);
    localparam logic [CFG_W-1:0]  SRC_H_RST = clamp_size(CFG_RESET, SRC_H_MAX);
    localparam logic [CFG_W-1:0]  DST_RST   = clamp_size(CFG_RESET, DST_MAX);

    // size registers hold clamped sizes
    logic [CFG_W-1:0]  src_w_reg;
    logic [CFG_W-1:0]  src_h_reg;
    logic [CFG_W-1:0]  dst_w_reg;
    logic [CFG_W-1:0]  dst_h_reg;

    logic [ADDR_W-1:0] load_idx_reg;
    logic [ADDR_W-1:0] load_idx_next;
    logic [PROD_W-1:0] frame_size;
    logic [CMP_W-1:0]  idx_inc;

    logic [POS_W-1:0]  row_reg;
    logic [POS_W-1:0]  row_next;
    logic [POS_W-1:0]  col_reg;
    logic [POS_W-1:0]  col_next;
    logic [POS_W:0]    row_inc;
    logic [POS_W:0]    col_inc;
    logic              row_end;
    logic              frame_end;

    logic [CFG_W-1:0]  q_row;
    logic [CFG_W-1:0]  q_col;
    logic              row_outside;
    logic              col_outside;
    logic              white;

    logic [PROD_W-1:0] addr_prod;
    logic [PROD_W:0]   addr_sum;
    logic [ADDR_W-1:0] addr_reg;

    logic [PIX_W-1:0]  mem [STORE_DEPTH];
    logic [PIX_W-1:0]  rd_data_reg;
    logic [PIX_W-1:0]  wr_pix;

    logic              rsp_valid_reg;
    rsp_word_t         rsp_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SRC_W_RST;
            src_h_reg <= SRC_H_RST;
            dst_w_reg <= DST_RST;
            dst_h_reg <= DST_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_w_reg <= clamp_size(cfg_data, SRC_W_MAX);
                CFG_SRC_HEIGHT: src_h_reg <= clamp_size(cfg_data, SRC_H_MAX);
                CFG_DST_WIDTH:  dst_w_reg <= clamp_size(cfg_data, DST_MAX);
                CFG_DST_HEIGHT: dst_h_reg <= clamp_size(cfg_data, DST_MAX);
                default:        src_w_reg <= src_w_reg;
            endcase
        end
    end

    // load index wraps at the end of the source frame, or when sizes shrank
    assign frame_size    = PROD_W'(src_w_reg) * PROD_W'(src_h_reg);
    assign idx_inc       = CMP_W'(load_idx_reg) + CMP_W'(1);
    assign load_idx_next = (idx_inc >= CMP_W'(frame_size)) ? '0 : idx_inc[ADDR_W-1:0];
    assign wr_pix        = {req_word.in_red, req_word.in_green, req_word.in_blue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_idx_reg <= '0;
        else if (cmd.load)
            load_idx_reg <= load_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[load_idx_reg] <= wr_pix;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[addr_reg];
    end

    // output raster position
    assign col_inc   = {1'b0, col_reg} + (POS_W+1)'(1);
    assign row_inc   = {1'b0, row_reg} + (POS_W+1)'(1);
    assign row_end   = (col_inc >= {1'b0, dst_w_reg});
    assign frame_end = row_end && (row_inc >= {1'b0, dst_h_reg});
    assign col_next  = row_end ? '0 : col_inc[POS_W-1:0];
    assign row_next  = frame_end ? '0 : (row_end ? row_inc[POS_W-1:0] : row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    nnis_map u_map_row
    (
        .clk     (clk),
        .cmd     (cmd),
        .pos     (row_reg),
        .src     (src_h_reg),
        .dst     (dst_h_reg),
        .quot    (q_row),
        .outside (row_outside)
    );

    nnis_map u_map_col
    (
        .clk     (clk),
        .cmd     (cmd),
        .pos     (col_reg),
        .src     (src_w_reg),
        .dst     (dst_w_reg),
        .quot    (q_col),
        .outside (col_outside)
    );

    assign addr_prod = PROD_W'(q_row) * PROD_W'(src_w_reg);
    assign addr_sum  = {1'b0, addr_prod} + (PROD_W+1)'(q_col);

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
            addr_reg <= ADDR_W'(addr_sum);
    end

    assign white = row_outside | col_outside;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_word_reg.out_blue     <= white ? CH_WHITE : rd_data_reg[CH_W-1:0];
            rsp_word_reg.out_green    <= white ? CH_WHITE : rd_data_reg[2*CH_W-1:CH_W];
            rsp_word_reg.out_red      <= white ? CH_WHITE : rd_data_reg[3*CH_W-1:2*CH_W];
            rsp_word_reg.out_row      <= row_reg[ROW_W-1:0];
            rsp_word_reg.out_col      <= col_reg[ROW_W-1:0];
            rsp_word_reg.filled_white <= white;
            rsp_word_reg.frame_last   <= frame_end;
        end
    end

    assign sts.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp_word     = rsp_word_reg;

endmodule
`default_nettype wire

// ----- rtl/core/nnis_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnis_ctrl: scaler sequencer
// Takes request words; load words go straight to the store, emit words step
// the datapath through map, divide, address, store read and output load.
// ----------------------------------------------------------------------------
module nnis_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  nnis_pkg::op_t        operation,
    output logic                 req_ready,
    input  nnis_pkg::sts_t       sts,
    output nnis_pkg::cmd_t       cmd
);
    import nnis_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_ADDR  = 6'b001000,
        S_READ  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.setup  = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                cnt_next   = STEP_W'(CFG_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (cnt_reg == '0)
                    state_next = S_ADDR;
                else
                    cnt_next = cnt_reg - STEP_W'(1);
            end
            S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/nearest_neighbor_image_scaler_unit.sv -----
// Load word: written to the store at the accept edge, one load word per cycle when idle.
// Emit word: result valid after divide, address and read; next request taken in that cycle.
// Emit time is set by the nine-step restoring divider in each axis mapper plus store read.
// A stalled output register holds the emit sequence in its last state until space frees.
// Reset clears sizes to 256 (clamped), load index and output position; store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_unit: nearest neighbor image scaler
// Loads a 24-bit source image in raster order and emits the resized image,
// one pixel per emit word, white where the mapped source falls outside.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_unit
#(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int MAX_DST_DIM    = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel: load or emit words
    input  logic                       req_valid,
    output logic                       req_ready,
    input  nnis_pkg::req_word_t        req_word,
    // response channel: output pixels
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output nnis_pkg::rsp_word_t        rsp_word,
    // size register writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  nnis_pkg::cfg_index_t       cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0] cfg_data
);
    import nnis_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // size writes are always accepted
    assign cfg_ready = 1'b1;

    // Sequencer: accepts words, drives at most one command per cycle
    nnis_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .operation (req_word.operation),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath: store, counters, mappers and output register
    nnis_dp
    #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .MAX_DST_DIM    (MAX_DST_DIM)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_word  (req_word),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word),
        .cmd       (cmd),
        .sts       (sts)
    );

    // An accepted emit word occupies the sequencer: no request taken next cycle
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_word.operation == OP_EMIT) |=> !req_ready)
        else $error("request taken while an emit word is in flight");

    // The sequencer issues at most one command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.setup, cmd.check, cmd.step, cmd.addr, cmd.out_load}))
        else $error("overlapping datapath commands");

    // Never overwrite an output word that has not been taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!rsp_valid || rsp_ready))
        else $error("output word overwritten");

    // A filled pixel is white on every channel
    a_white_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_word.filled_white |->
            (rsp_word.out_blue == CH_WHITE) && (rsp_word.out_green == CH_WHITE) &&
            (rsp_word.out_red == CH_WHITE))
        else $error("filled pixel is not white");

endmodule
`default_nettype wire

// ----- tb/sv/nnis_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pixel_checker: output pixel predictor and scoreboard
// Follows size writes and load words, predicts each emitted pixel and
// compares it field by field with the response channel.
// ----------------------------------------------------------------------------
module nnis_pixel_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  nnis_pkg::req_word_t        req_word,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  nnis_pkg::rsp_word_t        rsp_word,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  nnis_pkg::cfg_index_t       cfg_index,
    input  logic [nnis_pkg::CFG_W-1:0] cfg_data,
    output int                         mismatch_count,
    output int                         pixels_owed
);
    import nnis_pkg::*;

    localparam int unsigned DIM_LIMIT   = 256;
    localparam int unsigned STORE_DEPTH = 65536;

    logic [PIX_W-1:0] src_pixels [STORE_DEPTH];
    logic [CFG_W-1:0] size_reg [4];
    int unsigned      ld_pos;
    int unsigned      pos_row;
    int unsigned      pos_col;
    rsp_word_t        owed_pixels [$];

    function automatic int unsigned eff_size(logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > DIM_LIMIT)
            return DIM_LIMIT;
        return v;
    endfunction

    // Rounded inverse scale, exact in integers
    function automatic int unsigned source_index(int unsigned p, int unsigned src,
                                                 int unsigned dst);
        int unsigned d2;
        d2 = 2 * dst - 1;
        return (4 * p * src + d2) / (2 * d2);
    endfunction

    function automatic rsp_word_t next_pixel();
        int unsigned      sw;
        int unsigned      sh;
        int unsigned      dw;
        int unsigned      dh;
        int unsigned      sr;
        int unsigned      sc;
        logic             row_end;
        logic             frame_end;
        logic [PIX_W-1:0] px;
        rsp_word_t        w;
        sw = eff_size(size_reg[CFG_SRC_WIDTH]);
        sh = eff_size(size_reg[CFG_SRC_HEIGHT]);
        dw = eff_size(size_reg[CFG_DST_WIDTH]);
        dh = eff_size(size_reg[CFG_DST_HEIGHT]);
        sr = source_index(pos_row, sh, dh);
        sc = source_index(pos_col, sw, dw);
        row_end   = (pos_col + 1 >= dw);
        frame_end = row_end && (pos_row + 1 >= dh);
        if (sr < sh && sc < sw) begin
            px = src_pixels[sr * sw + sc];
            w.out_blue     = px[CH_W-1:0];
            w.out_green    = px[2*CH_W-1:CH_W];
            w.out_red      = px[3*CH_W-1:2*CH_W];
            w.filled_white = 1'b0;
        end
        else begin
            w.out_blue     = CH_WHITE;
            w.out_green    = CH_WHITE;
            w.out_red      = CH_WHITE;
            w.filled_white = 1'b1;
        end
        w.out_row    = ROW_W'(pos_row);
        w.out_col    = ROW_W'(pos_col);
        w.frame_last = frame_end;
        // advance the raster position, stale positions wrap on this emit
        if (row_end) begin
            pos_col = 0;
            pos_row = frame_end ? 0 : pos_row + 1;
        end
        else begin
            pos_col = pos_col + 1;
        end
        return w;
    endfunction

    function automatic void field_check(string tag, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic match_pixel(rsp_word_t got);
        rsp_word_t want;
        if (owed_pixels.size() == 0) begin
            $display("%0t: pixel with none owed, actual %p", $time, got);
            mismatch_count++;
        end
        else begin
            want = owed_pixels.pop_front();
            field_check("out_blue", want.out_blue, got.out_blue);
            field_check("out_green", want.out_green, got.out_green);
            field_check("out_red", want.out_red, got.out_red);
            field_check("out_row", want.out_row, got.out_row);
            field_check("out_col", want.out_col, got.out_col);
            field_check("filled_white", 8'(want.filled_white), 8'(got.filled_white));
            field_check("frame_last", 8'(want.frame_last), 8'(got.frame_last));
        end
    endtask

    initial mismatch_count = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            size_reg[CFG_SRC_WIDTH]  = CFG_RESET;
            size_reg[CFG_SRC_HEIGHT] = CFG_RESET;
            size_reg[CFG_DST_WIDTH]  = CFG_RESET;
            size_reg[CFG_DST_HEIGHT] = CFG_RESET;
            ld_pos  = 0;
            pos_row = 0;
            pos_col = 0;
            owed_pixels.delete();
            pixels_owed = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                size_reg[cfg_index] = cfg_data;
            if (rsp_valid && rsp_ready)
                match_pixel(rsp_word);
            if (req_valid && req_ready) begin
                if (req_word.operation == OP_LOAD) begin
                    src_pixels[ld_pos] = {req_word.in_red, req_word.in_green, req_word.in_blue};
                    if (ld_pos + 1 >= eff_size(size_reg[CFG_SRC_WIDTH])
                                      * eff_size(size_reg[CFG_SRC_HEIGHT]))
                        ld_pos = 0;
                    else
                        ld_pos = ld_pos + 1;
                end
                else begin
                    owed_pixels.push_back(next_pixel());
                end
            end
            pixels_owed = owed_pixels.size();
        end
    end

endmodule

// ----- tb/sv/nearest_neighbor_image_scaler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_unit_tb: scaler testbench top
// Loads source images and emits scaled frames over many size settings,
// with random gaps on both channels; the checker judges every pixel.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler_unit_tb;
    import nnis_pkg::*;

    localparam int RUN_ITEMS     = 600;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 20;     // settle time after the last owed pixel returns
    localparam int MAX_GAP       = 16;
    localparam int SRC_AREA_CAP  = 256;    // keep a source image loadable in few words

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_word_t        req_word;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_word_t        rsp_word;
    logic             cfg_valid;
    logic             cfg_ready;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int mismatch_count;
    int pixels_owed;
    int cycle_count = 0;
    int words_sent  = 0;
    bit send_burst  = 1'b0;
    bit take_burst  = 1'b0;

    // Stimulus bookkeeping: written size codes, the block's load pointer and
    // how many store entries from zero up hold loaded pixels. Emits wait until
    // the whole current source area is covered, so no unloaded entry is read.
    logic [CFG_W-1:0] sw_code;
    logic [CFG_W-1:0] sh_code;
    int unsigned      ld_ptr;
    int unsigned      loaded_span;

    always #6 clk = ~clk;

    nearest_neighbor_image_scaler_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nnis_pixel_checker chk
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_word       (req_word),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp_word       (rsp_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed)
    );

    // Watchdog: end a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL nearest_neighbor_image_scaler_unit");
            $finish;
        end
    end

    // Size code as the block uses it
    function automatic int unsigned dim_of(logic [CFG_W-1:0] code);
        if (code == '0)
            return 1;
        if (code > 256)
            return 256;
        return code;
    endfunction

    function automatic bit src_covered();
        return loaded_span >= dim_of(sw_code) * dim_of(sh_code);
    endfunction

    // Mostly random color, now and then all black or all white
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_src_dim();
        case ($urandom_range(0, 31))
            0:       return '0;
            1:       return CFG_W'(256);
            2:       return CFG_W'($urandom_range(257, 511));
            default: return CFG_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dst_dim();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_W'(256);
            2:       return CFG_W'($urandom_range(257, 511));
            3:       return '1;
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Present one request word after a random gap and hold it until taken.
    // Valid stays high on return; the next caller lowers it or reuses it.
    task automatic send_word(op_t op, logic [PIX_W-1:0] px);
        int        gap;
        req_word_t w;
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        w.operation = op;
        w.in_blue   = px[CH_W-1:0];
        w.in_green  = px[2*CH_W-1:CH_W];
        w.in_red    = px[3*CH_W-1:2*CH_W];
        req_valid <= 1'b1;
        req_word  <= w;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        words_sent++;
        if (op == OP_LOAD) begin
            // advance the load pointer mirror, wrap at the image area
            if (ld_ptr == loaded_span)
                loaded_span++;
            if (ld_ptr + 1 >= dim_of(sw_code) * dim_of(sh_code))
                ld_ptr = 0;
            else
                ld_ptr = ld_ptr + 1;
        end
        @(negedge clk);
    endtask

    // Hold the request side until every owed pixel is back and the block settles
    task automatic drain();
        req_valid <= 1'b0;
        while (pixels_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    // One setting: drain, write all four sizes, then mix loads and emits.
    // Emits go only once the source area is covered; top up with loads if not.
    task automatic run_phase(logic [CFG_W-1:0] sw, logic [CFG_W-1:0] sh,
                             logic [CFG_W-1:0] dw, logic [CFG_W-1:0] dh,
                             int n_load, int n_emit);
        int loads_left;
        int emits_left;
        bit can_emit;
        drain();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_DST_WIDTH, dw);
        write_reg(CFG_DST_HEIGHT, dh);
        cfg_valid <= 1'b0;
        sw_code = sw;
        sh_code = sh;
        send_burst = ($urandom_range(0, 3) == 0);
        take_burst = ($urandom_range(0, 3) == 0);
        loads_left = n_load;
        emits_left = n_emit;
        while (loads_left > 0 || emits_left > 0) begin
            if ($urandom_range(0, 19) == 0)
                drain();
            can_emit = (emits_left > 0) && src_covered();
            if (can_emit && (loads_left == 0 || $urandom_range(0, 1) == 0)) begin
                send_word(OP_EMIT, PIX_W'($urandom));
                emits_left--;
            end
            else begin
                send_word(OP_LOAD, pick_pixel());
                if (loads_left > 0)
                    loads_left--;
            end
        end
    endtask

    task automatic random_phase();
        logic [CFG_W-1:0] sw;
        logic [CFG_W-1:0] sh;
        logic [CFG_W-1:0] dw;
        logic [CFG_W-1:0] dh;
        int unsigned      area;
        int unsigned      frame;
        int               n_load;
        int               n_emit;
        bit               fresh;
        fresh = ($urandom_range(0, 1) == 0);
        if (fresh) begin
            sw = pick_src_dim();
            sh = pick_src_dim();
            if (dim_of(sw) * dim_of(sh) > SRC_AREA_CAP)
                sh = CFG_W'($urandom_range(0, 1));
        end
        else begin
            sw = sw_code;
            sh = sh_code;
        end
        area = dim_of(sw) * dim_of(sh);
        // fresh size: whole image, else 0 to 3 loads; sometimes a broken, partial load
        if ($urandom_range(0, 5) == 0)
            n_load = $urandom_range(0, area);
        else if (fresh)
            n_load = area;
        else
            n_load = $urandom_range(0, 3);
        dw = pick_dst_dim();
        dh = pick_dst_dim();
        frame = dim_of(dw) * dim_of(dh);
        if (frame <= 64)
            n_emit = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame) : frame;
        else if (frame <= 256 && $urandom_range(0, 3) == 0)
            n_emit = frame;
        else
            n_emit = $urandom_range(1, 40);
        run_phase(sw, sh, dw, dh, n_load, n_emit);
    endtask

    // Response side: random stall before each word, none in burst phases
    initial begin
        int stall;
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = take_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_valid && rsp_ready));
            @(negedge clk);
        end
    end

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SRC_WIDTH;
        cfg_data  = '0;
        sw_code     = CFG_RESET;
        sh_code     = CFG_RESET;
        ld_ptr      = 0;
        loaded_span = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // 2x2 source upscaled to 3x2: loads first, white fill at the right edge
        run_phase(CFG_W'(2), CFG_W'(2), CFG_W'(3), CFG_W'(2), 4, 6);
        // zero width reads as one, all-ones width saturates, zero height reads as one
        run_phase('0, CFG_W'(1), '1, '0, 1, 3);
        // shrink destination mid-row: stale column is mapped, then wraps
        run_phase(CFG_W'(2), CFG_W'(2), CFG_W'(2), CFG_W'(2), 0, 3);
        // partial load of a 3x3 image leaves the pointer at five
        run_phase(CFG_W'(3), CFG_W'(3), CFG_W'(1), CFG_W'(1), 5, 0);
        // shrink the source below the pointer: next load wraps it to zero
        run_phase(CFG_W'(2), CFG_W'(1), CFG_W'(1), CFG_W'(2), 1, 2);

        while (words_sent < RUN_ITEMS)
            random_phase();

        drain();
        if (mismatch_count == 0 && pixels_owed == 0)
            $display("PASS nearest_neighbor_image_scaler_unit");
        else
            $display("FAIL nearest_neighbor_image_scaler_unit");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/nnis_pkg.sv
rtl/core/nnis_map.sv
rtl/core/nnis_dp.sv
rtl/core/nnis_ctrl.sv
rtl/core/nearest_neighbor_image_scaler_unit.sv
tb/sv/nnis_pixel_checker.sv
tb/sv/nearest_neighbor_image_scaler_unit_tb.sv
